[rtl/bdgm_pkg.sv]
// ----------------------------------------------------------------------------
// bdgm_pkg
// Shared widths, defaults and helpers for the backward-difference gradient
// magnitude core and its port checker.
// ----------------------------------------------------------------------------
package bdgm_pkg;

  localparam int PIXEL_W        = 8;
  localparam int IMAGE_WIDTH_W  = 12;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST = IMAGE_WIDTH_W'(640);

  typedef logic [PIXEL_W-1:0] pixel_t;

  // Absolute difference of two pixels
  function automatic pixel_t abs_diff(input pixel_t a, input pixel_t b);
    pixel_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return d;
  endfunction

  // Half the sum of two absolute differences, truncated
  function automatic pixel_t half_sum(input pixel_t a, input pixel_t b);
    logic [PIXEL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIXEL_W:1];
  endfunction

endpackage

[rtl/backward_diff_gradient_magnitude_core.sv]
// ----------------------------------------------------------------------------
// backward_diff_gradient_magnitude_core
// Gradient magnitude (|cur-left| + |cur-up|) / 2 over a raster pixel stream,
// with the row above held in a one-line synchronous store.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_ready, in_pixel,           | in
//          | in_frame_start                          |
//  result  | out_valid, out_ready, out_magnitude     | out
//  config  | cfg_wr_en, cfg_wr_data (image width)    | in
//
//  One pixel per clock sustained while the output is not stalled; an accepted
//  transaction is registered in the read stage and then loaded into the
//  output register, from which it is taken.
//  The line store is read and written at the same column in the accept
//  cycle (read-first), so the pixel above is registered with the read stage.
//  Synchronous active-low reset clears position, left pixel and valid flags;
//  the line store is not cleared.
//  A stalled output holds; one more transaction waits in the read stage, and
//  in_ready drops only when both stages are full and out_ready is low.
// ----------------------------------------------------------------------------
module backward_diff_gradient_magnitude_core #(
  parameter int MAX_WIDTH = bdgm_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bdgm_pkg::PIXEL_W-1:0]       in_pixel,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bdgm_pkg::PIXEL_W-1:0]       out_magnitude,
  input  logic                               cfg_wr_en,
  input  logic [bdgm_pkg::IMAGE_WIDTH_W-1:0] cfg_wr_data
);
  import bdgm_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (COL_W + 1 > IMAGE_WIDTH_W) ? COL_W + 1 : IMAGE_WIDTH_W;
  localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

  // Configuration and control registers
  logic [IMAGE_WIDTH_W-1:0] width_r;
  logic [COL_W-1:0]         column_r, column_nxt;
  logic                     first_row_r, first_row_nxt;
  pixel_t                   left_r;
  logic                     s1_valid_r, s1_valid_nxt;
  pixel_t                   s1_pixel_r;
  pixel_t                   s1_left_r;
  logic                     s1_zero_r;
  logic                     out_valid_r, out_valid_nxt;
  pixel_t                   out_mag_r;

  // Line store
  pixel_t                   line_mem [MAX_WIDTH];
  pixel_t                   up_r;

  logic                     in_fire;
  logic                     out_load;
  logic [COL_W-1:0]         col_eff;
  logic                     first_row_eff;
  logic [CMP_W-1:0]         width_eff;
  logic [CMP_W-1:0]         col_inc;
  pixel_t                   mag;

  // Handshake: the output register frees up or the read stage is empty
  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_load;
  assign in_fire  = in_valid && in_ready;

  // Position of the current transaction, frame start puts it to the origin
  assign col_eff       = in_frame_start ? '0 : column_r;
  assign first_row_eff = in_frame_start ? 1'b1 : first_row_r;

  // Clamp width into 1..MAX_WIDTH
  always_comb begin
    width_eff = CMP_W'(width_r);
    if (width_eff == '0) begin
      width_eff = ONE_C;
    end else if (width_eff > MAX_W_C) begin
      width_eff = MAX_W_C;
    end
  end

  // Advance column, wrap at the row end
  always_comb begin
    col_inc       = CMP_W'(col_eff) + ONE_C;
    column_nxt    = column_r;
    first_row_nxt = first_row_r;
    if (in_fire) begin
      if (col_inc >= width_eff) begin
        column_nxt    = '0;
        first_row_nxt = 1'b0;
      end else begin
        column_nxt    = col_inc[COL_W-1:0];
        first_row_nxt = first_row_eff;
      end
    end
  end

  // Stage valid flags
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_ready) begin
      s1_valid_nxt = in_fire;
    end
  end

  // Magnitude from the read stage
  assign mag = s1_zero_r ? '0
             : half_sum(abs_diff(s1_pixel_r, s1_left_r), abs_diff(s1_pixel_r, up_r));

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= IMAGE_WIDTH_RST;
      column_r    <= '0;
      first_row_r <= 1'b1;
      left_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      column_r    <= column_nxt;
      first_row_r <= first_row_nxt;
      if (in_fire) begin
        left_r <= in_pixel;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_pixel;
      s1_left_r  <= left_r;
      s1_zero_r  <= first_row_eff || (col_eff == '0);
    end
  end

  // Line store: read old pixel above, write current pixel, same column
  always_ff @(posedge clk) begin
    if (in_fire) begin
      up_r              <= line_mem[col_eff];
      line_mem[col_eff] <= in_pixel;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_mag_r <= mag;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;

endmodule

[rtl/bdgm_checker.sv]
// ----------------------------------------------------------------------------
// bdgm_checker
// Port-level checks on the gradient magnitude core, bound to the top level.
// ----------------------------------------------------------------------------
module bdgm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bdgm_pkg::PIXEL_W-1:0] out_magnitude
);
  import bdgm_pkg::*;

  // Reset empties the output
  a_reset_clears : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Input stalls only when both stages are full and the output is blocked
  a_ready_only_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without an output stall");

  // A fresh result comes from a transaction accepted through the read stage
  a_result_has_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result with no matching transaction");

  // Hold a stalled result
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_magnitude)))
    else $error("stalled result dropped or changed");

endmodule

bind backward_diff_gradient_magnitude_core bdgm_checker u_bdgm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_magnitude (out_magnitude)
);
